// ===== rtl/vwbp_pkg.sv =====
// Shared types and constants for the variable-width bit packer.
package vwbp_pkg;

    localparam int WORD_BITS   = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [5:0] WIDTH_LIMIT = (WORD_BITS < 32) ? 6'(WORD_BITS) : 6'd32;
    localparam logic [5:0] ENTRY_BITS_RESET = 6'd32;
    localparam logic [4:0] LAST_BITS_RESET  = 5'd0;

    localparam logic CFG_ENTRY_BITS = 1'b0;
    localparam logic CFG_LAST_BITS  = 1'b1;

    typedef struct packed {
        logic [31:0] entry_word;
        logic        final_entry;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       end_of_stream;
        logic       empty_stream;
    } t_out_beat;

    typedef struct packed {
        logic [39:0] data;
        logic [2:0]  nres;
        logic        fin;
        logic        empty;
    } t_job;

endpackage

// ===== rtl/vwbp_front.sv =====
// Front end: config registers, bit accumulation and byte job classification.
module vwbp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [5:0]        i_cfg_data,
    input  logic              i_accept,
    input  vwbp_pkg::t_in_beat i_in,
    output logic              o_push,
    output vwbp_pkg::t_job    o_job
);
    import vwbp_pkg::*;

    logic [5:0]  r_entry_bits;
    logic [4:0]  r_last_bits;
    logic [6:0]  r_pend;
    logic [2:0]  r_pcnt;
    logic [6:0]  n_pend;
    logic [2:0]  n_pcnt;

    logic [5:0]  sel_bits;
    logic [5:0]  use_bits;
    logic [31:0] mask;
    logic [38:0] acc;
    logic [38:0] acc_shift;
    logic [5:0]  count;
    logic [2:0]  full_bytes;
    logic [2:0]  rem_bits;
    t_job        job;

    always_comb begin
        if (r_entry_bits == 6'd0) begin
            sel_bits = 6'd0;
        end else if (i_in.final_entry) begin
            sel_bits = {1'b0, r_last_bits};
        end else begin
            sel_bits = r_entry_bits;
        end
        use_bits = (sel_bits > WIDTH_LIMIT) ? WIDTH_LIMIT : sel_bits;
        mask = (use_bits >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << use_bits) - 32'd1);
        acc = {32'd0, r_pend} | ({7'd0, i_in.entry_word & mask} << r_pcnt);
        count = {3'd0, r_pcnt} + use_bits;
        full_bytes = count[5:3];
        rem_bits = count[2:0];
        acc_shift = acc >> {full_bytes, 3'b000};

        job.data  = {1'b0, acc};
        job.fin   = i_in.final_entry;
        job.empty = 1'b0;
        job.nres  = full_bytes;
        if (i_in.final_entry) begin
            if (rem_bits != 3'd0) begin
                job.nres = full_bytes + 3'd1;
            end else if (full_bytes == 3'd0) begin
                job.nres  = 3'd1;
                job.empty = 1'b1;
                job.data  = 40'd0;
            end
        end

        if (i_in.final_entry) begin
            n_pend = 7'd0;
            n_pcnt = 3'd0;
        end else begin
            n_pend = acc_shift[6:0];
            n_pcnt = rem_bits;
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.nres != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_bits <= ENTRY_BITS_RESET;
            r_last_bits  <= LAST_BITS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENTRY_BITS: r_entry_bits <= i_cfg_data;
                CFG_LAST_BITS:  r_last_bits  <= i_cfg_data[4:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 7'd0;
            r_pcnt <= 3'd0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
        end
    end

endmodule

// ===== rtl/vwbp_queue.sv =====
// Small job queue between the front end and the byte sequencer.
module vwbp_queue #(
    parameter int DEPTH = vwbp_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vwbp_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_avail,
    output vwbp_pkg::t_job o_job
);
    import vwbp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;
    assign n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
    assign n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/vwbp_back.sv =====
// Back end: steps through each job one byte per beat into the output register.
module vwbp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  vwbp_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vwbp_pkg::t_out_beat o_out
);
    import vwbp_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    t_out_beat  r_out;
    logic [2:0] n_idx;
    t_out_beat  n_out;
    logic       advance;
    logic       last_res;
    logic [7:0] sel_byte;

    assign advance  = !r_valid || i_out_ready;
    assign last_res = (r_idx == (i_job.nres - 3'd1));
    assign o_pop    = advance && i_avail && last_res;

    always_comb begin
        unique case (r_idx)
            3'd0:    sel_byte = i_job.data[7:0];
            3'd1:    sel_byte = i_job.data[15:8];
            3'd2:    sel_byte = i_job.data[23:16];
            3'd3:    sel_byte = i_job.data[31:24];
            3'd4:    sel_byte = i_job.data[39:32];
            default: sel_byte = 8'd0;
        endcase
        n_out.packed_byte   = sel_byte;
        n_out.end_of_stream = i_job.fin && last_res;
        n_out.empty_stream  = i_job.empty;
        n_idx = last_res ? 3'd0 : r_idx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (advance) begin
            r_valid <= i_avail;
            if (i_avail) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_avail) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/variable_width_bit_packer_top.sv =====
// Variable-width LSB-first bit packer: top level.
//
// Input channel (i_in_valid / o_in_ready / i_in) carries one entry word per beat
// with its final_entry flag. The low entry_bits bits of each non-final word and
// the low last_bits bits of the final word are appended LSB-first; each full
// byte leaves on the output channel (o_out_valid / i_out_ready / o_out), one
// byte per beat. The final word flushes a zero-padded partial byte and marks
// the last beat with end_of_stream; if the final word leaves no bits to send,
// the stream ends in one zero beat with end_of_stream and empty_stream set.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the
// user must write it only while the block is idle, which the block itself
// does not enforce. With the back end idle, the first byte of an item passes
// through the job queue and then the output register. The output sequencer
// sends one byte per cycle while the receiver is ready; a full 32-bit non-final
// entry causes four beats; the job queue lets intake run QUEUE_DEPTH items ahead.
// Reset (synchronous, active low) empties the queue and the output register,
// clears the pending bits and restores entry_bits to 32 and last_bits to 0.
// A stalled receiver holds the output beat; once the queue fills, o_in_ready
// drops until the sequencer frees an entry.
module variable_width_bit_packer_top #(
    parameter int QUEUE_DEPTH = vwbp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [5:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vwbp_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vwbp_pkg::t_out_beat o_out
);
    import vwbp_pkg::*;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_avail;
    t_job       push_job;
    t_job       head_job;
    logic       in_accept;

    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    vwbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_in       (i_in),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    vwbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_job   (head_job)
    );

    vwbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("job pushed into full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_avail)
        else $error("job popped from empty queue");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.empty_stream) |->
            (o_out.end_of_stream && (o_out.packed_byte == 8'd0)))
        else $error("empty beat without end marker or with data");
`endif

endmodule
